@@ design/isa16_pkg.sv @@
// shared types and constants for the isa16 core step unit
package isa16_pkg;

    localparam int MEM_WORDS_DEF = 65536;
    localparam logic [15:0] PC_RESET = 16'h3000;

    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_CHAR    = 3'd2;
    localparam logic [2:0] ST_ILLEGAL = 3'd3;
    localparam logic [2:0] ST_BADTRAP = 3'd4;
    localparam logic [2:0] ST_STRING  = 3'd5;
    localparam logic [2:0] ST_STOPPED = 3'd6;

    // opcodes
    localparam logic [3:0] OP_BR  = 4'h0;
    localparam logic [3:0] OP_ADD = 4'h1;
    localparam logic [3:0] OP_LD  = 4'h2;
    localparam logic [3:0] OP_ST  = 4'h3;
    localparam logic [3:0] OP_JSR = 4'h4;
    localparam logic [3:0] OP_AND = 4'h5;
    localparam logic [3:0] OP_LDR = 4'h6;
    localparam logic [3:0] OP_STR = 4'h7;
    localparam logic [3:0] OP_NOT = 4'h9;
    localparam logic [3:0] OP_LDI = 4'ha;
    localparam logic [3:0] OP_STI = 4'hb;
    localparam logic [3:0] OP_JMP = 4'hc;
    localparam logic [3:0] OP_LEA = 4'he;
    localparam logic [3:0] OP_TRAP = 4'hf;

    // trap vectors
    localparam logic [7:0] TV_GETC  = 8'h20;
    localparam logic [7:0] TV_OUT   = 8'h21;
    localparam logic [7:0] TV_PUTS  = 8'h22;
    localparam logic [7:0] TV_IN    = 8'h23;
    localparam logic [7:0] TV_PUTSP = 8'h24;
    localparam logic [7:0] TV_HALT  = 8'h25;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [15:0] data;
        logic [7:0]  key_char;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pc_value;
        logic [15:0] read_word;
        logic [7:0]  out_char;
        logic [2:0]  flags;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MREAD,
        S_FETCH,
        S_DECODE,
        S_IND,
        S_DATA,
        S_OUT
    } state_t;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        if (v == 16'd0)
            return CC_Z;
        else if (v[15])
            return CC_N;
        else
            return CC_P;
    endfunction

endpackage

@@ design/isa16_ram.sv @@
// generic single-port ram with registered read
module isa16_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end

endmodule

@@ design/isa16_processor_core_step_unit.sv @@
// top level: command decode, instruction sequencer and word memory
// Each input word is one command. A write goes through S_OUT, a read through S_MREAD, an
// execute through S_FETCH and S_DECODE: one single-port memory access per cycle (fetch,
// then up to one indirect read and one data read or write; LD, LDR add S_DATA, STI adds
// S_IND, LDI both). A refused execute (core stopped) goes through S_OUT. The result sits
// in an output register; a new word is taken once it is free. Memory is not cleared.
module isa16_processor_core_step_unit
    import isa16_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int AW = $clog2(MEM_WORDS);

    state_t      state_reg, state_next;
    in_word_t    cmd_reg;
    logic [15:0] regs_reg [8];
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic        run_reg, run_next;
    logic [15:0] ir_reg;
    logic        out_valid_reg;
    out_word_t   out_reg, res;

    logic        mem_we, mem_re;
    logic [15:0] mem_a16, mem_wdata, mem_rdata;
    logic        reg_we;
    logic [2:0]  reg_wa;
    logic [15:0] reg_wd;
    logic        fin;

    isa16_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_a16[AW-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // decode fields of the current instruction
    logic [3:0]  op;
    logic [2:0]  dr, sr1;
    logic [15:0] off9, off6, off11, imm5, opnd2, pc1, ea9, ea6, alu;
    logic [7:0]  tv;
    always_comb
    begin
        op    = ir_reg[15:12];
        dr    = ir_reg[11:9];
        sr1   = ir_reg[8:6];
        tv    = ir_reg[7:0];
        off9  = {{7{ir_reg[8]}}, ir_reg[8:0]};
        off6  = {{10{ir_reg[5]}}, ir_reg[5:0]};
        off11 = {{5{ir_reg[10]}}, ir_reg[10:0]};
        imm5  = {{11{ir_reg[4]}}, ir_reg[4:0]};
        opnd2 = ir_reg[5] ? imm5 : regs_reg[ir_reg[2:0]];
        pc1   = pc_reg;
        ea9   = pc1 + off9;
        ea6   = regs_reg[sr1] + off6;
        case (op)
            OP_ADD:  alu = regs_reg[sr1] + opnd2;
            OP_AND:  alu = regs_reg[sr1] & opnd2;
            default: alu = ~regs_reg[sr1];
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    case (in_data.cmd)
                        CMD_READ: state_next = S_MREAD;
                        CMD_EXEC: state_next = run_reg ? S_FETCH : S_OUT;
                        default:  state_next = S_OUT;
                    endcase
                end
            S_MREAD:  state_next = S_IDLE;
            S_FETCH:  state_next = S_DECODE;
            S_DECODE:
                case (op)
                    OP_LDI, OP_STI:         state_next = S_IND;
                    OP_LD, OP_LDR:          state_next = S_DATA;
                    default:                state_next = S_IDLE;
                endcase
            S_IND:    state_next = (op == OP_LDI) ? S_DATA : S_IDLE;
            S_DATA:   state_next = S_IDLE;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory, register file and architectural updates
    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_a16 = cmd_reg.address;
        mem_wdata = regs_reg[dr];
        reg_we = 1'b0;
        reg_wa = dr;
        reg_wd = alu;
        pc_next = pc_reg;
        cc_next = cc_reg;
        run_next = run_reg;
        fin = 1'b0;
        res = '0;
        res.read_word = ir_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    mem_a16 = in_data.address;
                    mem_wdata = in_data.data;
                    case (in_data.cmd)
                        CMD_WRITE: mem_we = 1'b1;
                        CMD_READ:  mem_re = 1'b1;
                        CMD_EXEC:
                        begin
                            mem_a16 = pc_reg;
                            mem_re = run_reg;
                        end
                        default: ;
                    endcase
                end
            S_MREAD:
            begin
                fin = 1'b1;
                res.read_word = mem_rdata;
            end
            S_FETCH:
                pc_next = pc_reg + 16'd1;
            S_DECODE:
            begin
                case (op)
                    OP_BR:
                        if ((dr & cc_reg) != 3'd0)
                            pc_next = ea9;
                    OP_ADD, OP_AND, OP_NOT:
                    begin
                        reg_we = 1'b1;
                        cc_next = cc_of(alu);
                    end
                    OP_LD, OP_LDI:
                    begin
                        mem_a16 = ea9;
                        mem_re = 1'b1;
                    end
                    OP_STI:
                    begin
                        mem_a16 = ea9;
                        mem_re = 1'b1;
                    end
                    OP_LDR:
                    begin
                        mem_a16 = ea6;
                        mem_re = 1'b1;
                    end
                    OP_LEA:
                    begin
                        reg_we = 1'b1;
                        reg_wd = ea9;
                        cc_next = cc_of(ea9);
                    end
                    OP_ST:
                    begin
                        mem_a16 = ea9;
                        mem_we = 1'b1;
                    end
                    OP_STR:
                    begin
                        mem_a16 = ea6;
                        mem_we = 1'b1;
                    end
                    OP_JMP:
                        pc_next = regs_reg[sr1];
                    OP_JSR:
                    begin
                        reg_we = 1'b1;
                        reg_wa = 3'd7;
                        reg_wd = pc1;
                        pc_next = ir_reg[11] ? (pc1 + off11) : regs_reg[sr1];
                    end
                    OP_TRAP:
                    begin
                        reg_we = 1'b1;
                        reg_wa = 3'd7;
                        reg_wd = pc1;
                        case (tv)
                            TV_GETC, TV_IN, TV_OUT, TV_PUTS, TV_PUTSP: ;
                            default: run_next = 1'b0;
                        endcase
                    end
                    default:
                        run_next = 1'b0;
                endcase
                if (state_next == S_IDLE)
                    fin = 1'b1;
            end
            S_IND:
            begin
                mem_a16 = mem_rdata;
                if (op == OP_LDI)
                    mem_re = 1'b1;
                else
                begin
                    mem_we = 1'b1;
                    fin = 1'b1;
                end
            end
            S_DATA:
            begin
                reg_we = 1'b1;
                reg_wd = mem_rdata;
                cc_next = cc_of(mem_rdata);
                fin = 1'b1;
            end
            S_OUT:
            begin
                fin = (cmd_reg.cmd != CMD_EXEC) || !run_reg;
                res.read_word = (cmd_reg.cmd == CMD_WRITE) ? cmd_reg.data : 16'd0;
                if (cmd_reg.cmd == CMD_EXEC)
                    res.status = ST_STOPPED;
            end
            default: ;
        endcase
        // status for execute completion
        if (state_reg == S_DECODE)
        begin
            case (op)
                OP_TRAP:
                    case (tv)
                        TV_GETC:
                        begin
                            reg_wa = 3'd0;
                            reg_wd = {8'd0, cmd_reg.key_char};
                            cc_next = cc_of(reg_wd);
                        end
                        TV_IN:
                        begin
                            reg_wa = 3'd0;
                            reg_wd = {8'd0, cmd_reg.key_char};
                            cc_next = cc_of(reg_wd);
                            res.out_char = cmd_reg.key_char;
                            res.status = ST_CHAR;
                        end
                        TV_OUT:
                        begin
                            res.out_char = regs_reg[0][7:0];
                            res.status = ST_CHAR;
                        end
                        TV_PUTS, TV_PUTSP: res.status = ST_STRING;
                        TV_HALT:           res.status = ST_HALT;
                        default:           res.status = ST_BADTRAP;
                    endcase
                OP_BR, OP_ADD, OP_AND, OP_NOT, OP_LD, OP_LDI, OP_LDR, OP_LEA,
                OP_ST, OP_STI, OP_STR, OP_JMP, OP_JSR: res.status = ST_OK;
                default: res.status = ST_ILLEGAL;
            endcase
        end
        res.pc_value = pc_next;
        res.flags = cc_next;
    end

    // the traps that write r0 (GETC and IN) also write r7 in the same update
    logic r7_also;
    assign r7_also = (state_reg == S_DECODE) && (op == OP_TRAP)
                     && ((tv == TV_GETC) || (tv == TV_IN));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= PC_RESET;
            cc_reg <= CC_Z;
            run_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            cc_reg <= cc_next;
            run_reg <= run_next;
            if (r7_also)
                regs_reg[7] <= pc1;
            if (reg_we)
                regs_reg[reg_wa] <= reg_wd;
            if (fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= in_data;
        if (state_reg == S_FETCH)
            ir_reg <= mem_rdata;
        if (fin)
            out_reg <= res;
    end

endmodule

@@ design/isa16_checker.sv @@
// port-level checks for the isa16 core step unit
module isa16_checker
    import isa16_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // no new word while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");

    // result never appears the cycle after accept
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    // flags always one-hot
    a_cc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(out_data.flags)) else $error("flags not one-hot");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped");

endmodule

bind isa16_processor_core_step_unit isa16_checker u_isa16_checker (.*);
